// ----- rtl/job_shop_gap_fill_scheduler_macros.svh -----
// assertion macros for the job shop gap fill scheduler
`ifndef JOB_SHOP_GAP_FILL_SCHEDULER_MACROS_SVH
`define JOB_SHOP_GAP_FILL_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define JSGF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define JSGF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define JSGF_ASSERT_IMPL(lbl, ante, cons)
`define JSGF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/jsgf_pkg.sv -----
// shared types and constants of the job shop gap fill scheduler
package jsgf_pkg;

    localparam int TIME_W = 24;
    localparam int DUR_W  = 16;
    localparam int CFG_W  = 5;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_SCHED = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam logic [1:0] REG_MACHINES = 2'd0;
    localparam logic [1:0] REG_JOBS     = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPCHK,
        S_SCAN,
        S_POSP,
        S_POS,
        S_SHP,
        S_SHIFT,
        S_INS
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] fin;
        logic [TIME_W-1:0] start;
    } span_t;

endpackage

// ----- rtl/jsgf_ram.sv -----
// generic one write one read port ram with registered read data
module jsgf_ram
    import jsgf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/job_shop_gap_fill_scheduler.sv -----
// job shop list scheduler with earliest gap insertion, top level
// load, clear and requests rejected on index: result valid the cycle after the transaction
// schedule: a bad stored machine or a full timeline ends in the op check, an empty one goes
//   straight to insert; otherwise scan the n intervals on the machine (n < SLOTS_PER_MACHINE),
//   then search the insertion position, shift the later intervals up and insert; one busy ram port
// one request at a time: s_tready is low while working or while a result waits
// async reset clears counters, finishes and makespan; tables and timelines hold no reset
`include "job_shop_gap_fill_scheduler_macros.svh"
module job_shop_gap_fill_scheduler
    import jsgf_pkg::*;
#(
    parameter int MAX_JOBS          = 16,
    parameter int MAX_MACHINES      = 16,
    parameter int SLOTS_PER_MACHINE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // job[3:0], op_number[7:4], machine[11:8], duration[27:12]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // start[23:0], finish[47:24], makespan[71:48]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int JW  = MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1;
    localparam int MW  = MAX_MACHINES > 1 ? $clog2(MAX_MACHINES) : 1;
    localparam int CW  = $clog2(SLOTS_PER_MACHINE + 1);
    localparam int OCW = $clog2(MAX_MACHINES + 1);
    localparam int OPD = MAX_JOBS * MAX_MACHINES;
    localparam int OAW = OPD > 1 ? $clog2(OPD) : 1;
    localparam int BD  = MAX_MACHINES * SLOTS_PER_MACHINE;
    localparam int BAW = BD > 1 ? $clog2(BD) : 1;
    localparam logic [6:0]    MAXM7 = 7'(MAX_MACHINES);
    localparam logic [6:0]    MAXJ7 = 7'(MAX_JOBS);
    localparam logic [CW-1:0] SLOTS = CW'(SLOTS_PER_MACHINE);

    // configuration registers
    logic [CFG_W-1:0] machines_reg, jobs_reg;
    logic [6:0]       nm, nj;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            machines_reg <= CFG_W'(16);
            jobs_reg     <= CFG_W'(16);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MACHINES: machines_reg <= cfg_data;
                REG_JOBS:     jobs_reg     <= cfg_data;
                default:      ;
            endcase
        end
    end

    // effective counts, clamped to 1..max
    always_comb
    begin
        nm = {2'b00, machines_reg};
        if (nm == 7'd0) nm = 7'd1;
        if (nm > MAXM7) nm = MAXM7;
        nj = {2'b00, jobs_reg};
        if (nj == 7'd0) nj = 7'd1;
        if (nj > MAXJ7) nj = MAXJ7;
    end

    // request fields
    logic [1:0]       in_mode;
    logic [3:0]       in_job, in_opn, in_mach;
    logic [DUR_W-1:0] in_dur;
    logic             in_acc;

    assign in_mode = s_tuser;
    assign in_job  = s_tdata[3:0];
    assign in_opn  = s_tdata[7:4];
    assign in_mach = s_tdata[11:8];
    assign in_dur  = s_tdata[27:12];
    assign in_acc  = s_tvalid & s_tready;

    // per job and per machine counters
    logic [OCW-1:0]    next_op_count_reg [MAX_JOBS];
    logic [TIME_W-1:0] job_finish_reg [MAX_JOBS];
    logic [CW-1:0]     interval_count_reg [MAX_MACHINES];
    logic [TIME_W-1:0] makespan_reg;

    // sequencer state
    state_t            state_reg, state_next;
    logic [JW-1:0]     job_reg, job_next;
    logic [MW-1:0]     mach_reg, mach_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     pos_reg, pos_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [TIME_W-1:0] out_start_reg, out_start_next;
    logic [TIME_W-1:0] out_fin_reg, out_fin_next;
    logic [1:0]        out_status_reg, out_status_next;

    // operation table
    logic             op_we;
    logic [OAW-1:0]   op_waddr, op_raddr;
    logic [19:0]      op_rdata;

    // busy interval timelines
    logic             bz_we;
    logic [BAW-1:0]   bz_waddr, bz_raddr;
    span_t            bz_wdata, bz_rdata;
    logic [MW-1:0]    rd_mach;
    logic [CW-1:0]    rd_idx, wr_idx;

    // shared datapath
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] fin_sat;
    logic [JW-1:0]     in_jidx;
    logic [MW-1:0]     op_midx;
    logic              commit, clear;

    assign in_jidx = JW'(in_job);
    assign op_midx = MW'(op_rdata[3:0]);
    assign sum     = {1'b0, t_reg} + (TIME_W + 1)'(dur_reg);
    assign fin_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    assign op_waddr = OAW'(int'(in_jidx) * MAX_MACHINES + int'(in_opn));
    assign op_raddr = OAW'(int'(in_jidx) * MAX_MACHINES + int'(next_op_count_reg[in_jidx]));
    assign bz_raddr = BAW'(int'(rd_mach) * SLOTS_PER_MACHINE + int'(rd_idx));
    assign bz_waddr = BAW'(int'(mach_reg) * SLOTS_PER_MACHINE + int'(wr_idx));

    jsgf_ram #(
        .WIDTH (20),
        .DEPTH (OPD)
    ) u_op_ram (
        .clk   (clk),
        .we    (op_we),
        .waddr (op_waddr),
        .wdata ({in_dur, in_mach}),
        .raddr (op_raddr),
        .rdata (op_rdata)
    );

    jsgf_ram #(
        .WIDTH (2 * TIME_W),
        .DEPTH (BD)
    ) u_busy_ram (
        .clk   (clk),
        .we    (bz_we),
        .waddr (bz_waddr),
        .wdata (bz_wdata),
        .raddr (bz_raddr),
        .rdata (bz_rdata)
    );

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        mach_next       = mach_reg;
        dur_next        = dur_reg;
        t_next          = t_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg;
        out_start_next  = out_start_reg;
        out_fin_next    = out_fin_reg;
        out_status_next = out_status_reg;
        op_we           = 1'b0;
        bz_we           = 1'b0;
        bz_wdata        = bz_rdata;
        wr_idx          = idx_reg;
        rd_mach         = mach_reg;
        rd_idx          = '0;
        commit          = 1'b0;
        clear           = 1'b0;
        s_tready        = (state_reg == S_IDLE) && !out_valid_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    out_start_next  = '0;
                    out_fin_next    = '0;
                    out_status_next = ST_OK;
                    job_next        = in_jidx;
                    case (in_mode)
                        MODE_LOAD:
                        begin
                            out_valid_next = 1'b1;
                            if ({3'b000, in_job} >= nj || {3'b000, in_opn} >= nm
                                || {3'b000, in_mach} >= nm)
                            begin
                                out_status_next = ST_BAD;
                            end
                            else
                            begin
                                op_we = 1'b1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            clear          = 1'b1;
                        end
                        MODE_SCHED:
                        begin
                            if ({3'b000, in_job} >= nj
                                || 7'(next_op_count_reg[in_jidx]) >= nm)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_BAD;
                            end
                            else
                            begin
                                state_next = S_OPCHK;
                            end
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_BAD;
                        end
                    endcase
                end
            end
            S_OPCHK:
            begin
                mach_next = op_midx;
                dur_next  = op_rdata[19:4];
                t_next    = job_finish_reg[job_reg];
                cnt_next  = interval_count_reg[op_midx];
                idx_next  = '0;
                pos_next  = '0;
                rd_mach   = op_midx;
                if ({3'b000, op_rdata[3:0]} >= nm)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_BAD;
                    state_next      = S_IDLE;
                end
                else if (interval_count_reg[op_midx] >= SLOTS)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_FULL;
                    state_next      = S_IDLE;
                end
                else if (interval_count_reg[op_midx] == '0)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // first fit: stop at a gap wide enough, else push past this interval
                if (sum <= {1'b0, bz_rdata.start})
                begin
                    state_next = S_POSP;
                end
                else
                begin
                    if (t_reg < bz_rdata.fin)
                    begin
                        t_next = bz_rdata.fin;
                    end
                    if (idx_reg + 1'b1 == cnt_reg)
                    begin
                        state_next = S_POSP;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_idx   = idx_reg + 1'b1;
                    end
                end
            end
            S_POSP:
            begin
                rd_idx     = '0;
                idx_next   = '0;
                state_next = S_POS;
            end
            S_POS:
            begin
                // insertion point: first interval starting at or after t
                if (bz_rdata.start < t_reg)
                begin
                    if (idx_reg + 1'b1 == cnt_reg)
                    begin
                        pos_next   = cnt_reg;
                        state_next = S_SHP;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_idx   = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    pos_next   = idx_reg;
                    state_next = S_SHP;
                end
            end
            S_SHP:
            begin
                if (pos_reg == cnt_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    rd_idx     = cnt_reg - 1'b1;
                    idx_next   = cnt_reg;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                bz_we    = 1'b1;
                wr_idx   = idx_reg;
                bz_wdata = bz_rdata;
                if (idx_reg - 1'b1 == pos_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    rd_idx   = idx_reg - 2'd2;
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_INS:
            begin
                bz_we           = 1'b1;
                wr_idx          = pos_reg;
                bz_wdata.start  = t_reg;
                bz_wdata.fin    = fin_sat;
                commit          = 1'b1;
                out_valid_next  = 1'b1;
                out_start_next  = t_reg;
                out_fin_next    = fin_sat;
                out_status_next = sum[TIME_W] ? ST_SAT : ST_OK;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        mach_reg       <= mach_next;
        dur_reg        <= dur_next;
        t_reg          <= t_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        out_start_reg  <= out_start_next;
        out_fin_reg    <= out_fin_next;
        out_status_reg <= out_status_next;
    end

    // schedule bookkeeping, cleared by reset and by a clear request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                next_op_count_reg[i] <= '0;
                job_finish_reg[i]    <= '0;
            end
            for (int i = 0; i < MAX_MACHINES; i++)
            begin
                interval_count_reg[i] <= '0;
            end
            makespan_reg <= '0;
        end
        else if (clear)
        begin
            for (int i = 0; i < MAX_JOBS; i++)
            begin
                next_op_count_reg[i] <= '0;
                job_finish_reg[i]    <= '0;
            end
            for (int i = 0; i < MAX_MACHINES; i++)
            begin
                interval_count_reg[i] <= '0;
            end
            makespan_reg <= '0;
        end
        else if (commit)
        begin
            next_op_count_reg[job_reg] <= next_op_count_reg[job_reg] + 1'b1;
            interval_count_reg[mach_reg] <= cnt_reg + 1'b1;
            if (fin_sat > job_finish_reg[job_reg])
            begin
                job_finish_reg[job_reg] <= fin_sat;
            end
            if (fin_sat > makespan_reg)
            begin
                makespan_reg <= fin_sat;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {makespan_reg, out_fin_reg, out_start_reg};
    assign m_tuser  = out_status_reg;

    // a new request is only taken once the previous result has gone
    `JSGF_ASSERT_IMPL(a_ready_no_result, s_tready, !m_tvalid)
    // the insert step always produces a result
    `JSGF_ASSERT_NEXT(a_insert_result, state_reg == S_INS, m_tvalid)
    // a clear request leaves a zero makespan behind
    `JSGF_ASSERT_NEXT(a_clear_zero, in_acc && in_mode == MODE_CLEAR, makespan_reg == '0)
    // the shift pass never writes at or below the insertion point
    `JSGF_ASSERT_IMPL(a_shift_above_pos, state_reg == S_SHIFT, idx_reg > pos_reg)

endmodule
